>>> hdl/ips_pkg.sv
// Shared types and constants for the inverter protection supervisor.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package ips_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LimW     = 15;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned OcHoldW  = 8;
  localparam int unsigned SampW    = 16;
  localparam int unsigned ModeW    = 2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_AC_LIMIT   = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_DC_LIMIT   = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_OC_HOLD    = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_VDC_MIN    = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_VQ_TOL     = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_FREQ_TOL   = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_SYNC_HOLD  = 3'd6;
  localparam logic [CfgAddrW-1:0] REG_UNSYNC_HOLD = 3'd7;

  // Mode codes as seen on the result port
  localparam logic [ModeW-1:0] MODE_IDLE  = 2'd0;
  localparam logic [ModeW-1:0] MODE_POWER = 2'd1;
  localparam logic [ModeW-1:0] MODE_ERROR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_POWER = 3'b010,
    ST_ERROR = 3'b100
  } mode_state_e;

  typedef struct packed {
    logic [LimW-1:0]    ac_limit;
    logic [LimW-1:0]    dc_limit;
    logic [OcHoldW-1:0] oc_hold;
    logic [LimW-1:0]    vdc_min;
    logic [LimW-1:0]    vq_tol;
    logic [LimW-1:0]    freq_tol;
    logic [HoldW-1:0]   sync_hold;
    logic [HoldW-1:0]   unsync_hold;
  } cfg_t;

  typedef struct packed {
    logic locked;  // lock state after this tick
    logic lost;    // lock dropped on this tick
  } lock_stat_t;

  // Strict window test: -tol < v < tol
  function automatic logic in_window(logic signed [SampW-1:0] v, logic [LimW-1:0] tol);
    logic signed [SampW:0] vs;
    logic signed [SampW:0] ts;
    vs = {v[SampW-1], v};
    ts = signed'({2'b00, tol});
    return (vs < ts) && (vs > -ts);
  endfunction

  // Magnitude test: v > lim or v < -lim
  function automatic logic out_window(logic signed [SampW-1:0] v, logic [LimW-1:0] lim);
    logic signed [SampW:0] vs;
    logic signed [SampW:0] ls;
    vs = {v[SampW-1], v};
    ls = signed'({2'b00, lim});
    return (vs > ls) || (vs < -ls);
  endfunction

endpackage

>>> hdl/ips_cfg.sv
// Configuration register file of the supervisor.
// Depends on ips_pkg for register indexes and cfg_t.
`timescale 1ns / 1ps

module ips_cfg
  import ips_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_AC_LIMIT:    cfg_d.ac_limit    = cfg_wdata_i[LimW-1:0];
        REG_DC_LIMIT:    cfg_d.dc_limit    = cfg_wdata_i[LimW-1:0];
        REG_OC_HOLD:     cfg_d.oc_hold     = cfg_wdata_i[OcHoldW-1:0];
        REG_VDC_MIN:     cfg_d.vdc_min     = cfg_wdata_i[LimW-1:0];
        REG_VQ_TOL:      cfg_d.vq_tol      = cfg_wdata_i[LimW-1:0];
        REG_FREQ_TOL:    cfg_d.freq_tol    = cfg_wdata_i[LimW-1:0];
        REG_SYNC_HOLD:   cfg_d.sync_hold   = cfg_wdata_i[HoldW-1:0];
        REG_UNSYNC_HOLD: cfg_d.unsync_hold = cfg_wdata_i[HoldW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ac_limit    <= LimW'(3000);
      cfg_q.dc_limit    <= LimW'(3000);
      cfg_q.oc_hold     <= OcHoldW'(3);
      cfg_q.vdc_min     <= LimW'(4300);
      cfg_q.vq_tol      <= LimW'(1075);
      cfg_q.freq_tol    <= LimW'(3142);
      cfg_q.sync_hold   <= HoldW'(100);
      cfg_q.unsync_hold <= HoldW'(10);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/ips_lock.sv
// PLL lock detector: a single hold counter shared by the sync and unsync holds.
// Depends on ips_pkg; state advances only on a tick strobe from the top level.
`timescale 1ns / 1ps

module ips_lock
  import ips_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tick_i,
  input  logic                    pll_enable_i,
  input  logic signed [SampW-1:0] grid_q_voltage_i,
  input  logic signed [SampW-1:0] freq_deviation_i,
  input  cfg_t                    cfg_i,
  output lock_stat_t              stat_o
);

  logic             locked_q, locked_d;
  logic [HoldW-1:0] count_q, count_d;
  logic [HoldW-1:0] count_inc;
  logic             good, counts, lost;

  always_comb begin
    good      = in_window(grid_q_voltage_i, cfg_i.vq_tol) &&
                in_window(freq_deviation_i, cfg_i.freq_tol);
    counts    = locked_q ? !good : good;
    count_inc = counts ? count_q + HoldW'(1) : '0;
    locked_d  = locked_q;
    count_d   = count_inc;
    lost      = 1'b0;
    if (!pll_enable_i) begin
      locked_d = 1'b0;
      count_d  = '0;
    end else if (!locked_q) begin
      if (count_inc >= cfg_i.sync_hold) begin
        locked_d = 1'b1;
        count_d  = '0;
      end
    end else if (count_inc >= cfg_i.unsync_hold) begin
      locked_d = 1'b0;
      lost     = 1'b1;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0;
      count_q  <= '0;
    end else if (tick_i) begin
      locked_q <= locked_d;
      count_q  <= count_d;
    end
  end

  assign stat_o.locked = locked_d;
  assign stat_o.lost   = lost;

endmodule

>>> hdl/ips_prot.sv
// Overcurrent debouncer, DC undervoltage check, sticky flags and mode machine.
// Depends on ips_pkg; takes the lock-lost event from ips_lock.
`timescale 1ns / 1ps

module ips_prot
  import ips_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tick_i,
  input  logic signed [SampW-1:0] phase_a_current_i,
  input  logic signed [SampW-1:0] phase_b_current_i,
  input  logic signed [SampW-1:0] phase_c_current_i,
  input  logic signed [SampW-1:0] dc_current_i,
  input  logic signed [SampW-1:0] dc_voltage_filtered_i,
  input  logic                    request_power_i,
  input  logic                    clear_flags_i,
  input  logic                    lock_lost_i,
  input  cfg_t                    cfg_i,
  output logic [ModeW-1:0]        mode_o,
  output logic                    pwm_enable_o,
  output logic                    fault_free_o,
  output logic                    overcurrent_flag_o,
  output logic                    undervoltage_flag_o,
  output logic                    lock_lost_flag_o
);

  mode_state_e        state_q, state_d;
  logic [OcHoldW-1:0] oc_cnt_q, oc_cnt_d;
  logic               oc_flag_q, oc_flag_d;
  logic               uv_flag_q, uv_flag_d;
  logic               ll_flag_q, ll_flag_d;
  logic               over_tick, over, under, ok, err_clear;

  always_comb begin
    over_tick = out_window(phase_a_current_i, cfg_i.ac_limit) ||
                out_window(phase_b_current_i, cfg_i.ac_limit) ||
                out_window(phase_c_current_i, cfg_i.ac_limit) ||
                (signed'({dc_current_i[SampW-1], dc_current_i}) >
                 signed'({2'b00, cfg_i.dc_limit}));
    // count successive over ticks, hold at the limit
    if (!over_tick) begin
      oc_cnt_d = '0;
    end else if (oc_cnt_q < cfg_i.oc_hold) begin
      oc_cnt_d = oc_cnt_q + OcHoldW'(1);
    end else begin
      oc_cnt_d = oc_cnt_q;
    end
    over  = oc_cnt_d >= cfg_i.oc_hold;
    under = signed'({dc_voltage_filtered_i[SampW-1], dc_voltage_filtered_i}) <
            signed'({2'b00, cfg_i.vdc_min});
    ok    = !under && !over;

    err_clear = 1'b0;
    state_d   = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (request_power_i && ok) state_d = ST_POWER;
      end
      ST_POWER: begin
        if (!ok) state_d = ST_ERROR;
        else if (!request_power_i) state_d = ST_IDLE;
      end
      ST_ERROR: begin
        if (!request_power_i) begin
          state_d   = ST_IDLE;
          err_clear = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // clear at tick start, set by this tick's events, drop on leaving error
    oc_flag_d = ((oc_flag_q && !clear_flags_i) || over) && !err_clear;
    uv_flag_d = ((uv_flag_q && !clear_flags_i) || under) && !err_clear;
    ll_flag_d = ((ll_flag_q && !clear_flags_i) || lock_lost_i) && !err_clear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      oc_cnt_q  <= '0;
      oc_flag_q <= 1'b0;
      uv_flag_q <= 1'b0;
      ll_flag_q <= 1'b0;
    end else if (tick_i) begin
      state_q   <= state_d;
      oc_cnt_q  <= oc_cnt_d;
      oc_flag_q <= oc_flag_d;
      uv_flag_q <= uv_flag_d;
      ll_flag_q <= ll_flag_d;
    end
  end

  always_comb begin
    unique case (state_d)
      ST_POWER: mode_o = MODE_POWER;
      ST_ERROR: mode_o = MODE_ERROR;
      default:  mode_o = MODE_IDLE;
    endcase
  end

  assign pwm_enable_o        = (state_d == ST_POWER);
  assign fault_free_o        = ok;
  assign overcurrent_flag_o  = oc_flag_d;
  assign undervoltage_flag_o = uv_flag_d;
  assign lock_lost_flag_o    = ll_flag_d;

endmodule

>>> hdl/inverter_protection_supervisor.sv
// Top level of the inverter protection supervisor: input register, tick logic, result register.
// Depends on ips_pkg, ips_cfg, ips_lock and ips_prot.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid_i/in_stall_o | phase currents, dc current/voltage, vq, dw,
//           |                       | request_power, pll_enable, clear_flags
//   out     | out_valid_o/out_stall_i | mode, pwm_enable, fault_free, flags, pll_locked
//   cfg     | cfg_we_i              | cfg_addr_i, cfg_wdata_i
//
// One beat per cycle sustained while out_stall_i is low.
// Each tick's state update happens as the beat moves from the input register
// into the result register, through combinational compare and counter logic.
// Reset clears control state and loads the register defaults.
// A stalled result register holds the input register; the input stalls only
// when both registers are full and the output is stalled.
`timescale 1ns / 1ps

module inverter_protection_supervisor
  import ips_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrW-1:0]     cfg_addr_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [SampW-1:0] phase_a_current_i,
  input  logic signed [SampW-1:0] phase_b_current_i,
  input  logic signed [SampW-1:0] phase_c_current_i,
  input  logic signed [SampW-1:0] dc_current_i,
  input  logic signed [SampW-1:0] dc_voltage_filtered_i,
  input  logic signed [SampW-1:0] grid_q_voltage_i,
  input  logic signed [SampW-1:0] freq_deviation_i,
  input  logic                    request_power_i,
  input  logic                    pll_enable_i,
  input  logic                    clear_flags_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ModeW-1:0]        mode_o,
  output logic                    pwm_enable_o,
  output logic                    fault_free_o,
  output logic                    overcurrent_flag_o,
  output logic                    undervoltage_flag_o,
  output logic                    lock_lost_flag_o,
  output logic                    pll_locked_o
);

  cfg_t       cfg;
  lock_stat_t lock_stat;

  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic accept, advance;

  logic signed [SampW-1:0] ia_q, ib_q, ic_q, idc_q, vdc_q, vq_q, dw_q;
  logic                    req_q, pll_en_q, clr_q;

  logic [ModeW-1:0] mode_d, mode_q;
  logic             pwm_d, ok_d, oc_d, uv_d, ll_d;
  logic             pwm_q, ok_q, oc_q, uv_q, ll_q, locked_q;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // capture input beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ia_q     <= phase_a_current_i;
      ib_q     <= phase_b_current_i;
      ic_q     <= phase_c_current_i;
      idc_q    <= dc_current_i;
      vdc_q    <= dc_voltage_filtered_i;
      vq_q     <= grid_q_voltage_i;
      dw_q     <= freq_deviation_i;
      req_q    <= request_power_i;
      pll_en_q <= pll_enable_i;
      clr_q    <= clear_flags_i;
    end
  end

  ips_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ips_lock u_lock (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (advance),
    .pll_enable_i     (pll_en_q),
    .grid_q_voltage_i (vq_q),
    .freq_deviation_i (dw_q),
    .cfg_i            (cfg),
    .stat_o           (lock_stat)
  );

  ips_prot u_prot (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .tick_i                (advance),
    .phase_a_current_i     (ia_q),
    .phase_b_current_i     (ib_q),
    .phase_c_current_i     (ic_q),
    .dc_current_i          (idc_q),
    .dc_voltage_filtered_i (vdc_q),
    .request_power_i       (req_q),
    .clear_flags_i         (clr_q),
    .lock_lost_i           (lock_stat.lost),
    .cfg_i                 (cfg),
    .mode_o                (mode_d),
    .pwm_enable_o          (pwm_d),
    .fault_free_o          (ok_d),
    .overcurrent_flag_o    (oc_d),
    .undervoltage_flag_o   (uv_d),
    .lock_lost_flag_o      (ll_d)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_q   <= mode_d;
      pwm_q    <= pwm_d;
      ok_q     <= ok_d;
      oc_q     <= oc_d;
      uv_q     <= uv_d;
      ll_q     <= ll_d;
      locked_q <= lock_stat.locked;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mode_o              = mode_q;
  assign pwm_enable_o        = pwm_q;
  assign fault_free_o        = ok_q;
  assign overcurrent_flag_o  = oc_q;
  assign undervoltage_flag_o = uv_q;
  assign lock_lost_flag_o    = ll_q;
  assign pll_locked_o        = locked_q;

endmodule

>>> dv/ips_supervisor_checker.sv
// Scoreboard for the inverter protection supervisor: tracks register writes, predicts each
// result beat from its input tick and compares the fields in order. Depends on ips_pkg.
`timescale 1ns / 1ps

module ips_supervisor_checker
  import ips_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrW-1:0]     cfg_addr_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_o,
  input  logic signed [SampW-1:0] phase_a_current_i,
  input  logic signed [SampW-1:0] phase_b_current_i,
  input  logic signed [SampW-1:0] phase_c_current_i,
  input  logic signed [SampW-1:0] dc_current_i,
  input  logic signed [SampW-1:0] dc_voltage_filtered_i,
  input  logic signed [SampW-1:0] grid_q_voltage_i,
  input  logic signed [SampW-1:0] freq_deviation_i,
  input  logic                    request_power_i,
  input  logic                    pll_enable_i,
  input  logic                    clear_flags_i,
  input  logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic [ModeW-1:0]        mode_o,
  input  logic                    pwm_enable_o,
  input  logic                    fault_free_o,
  input  logic                    overcurrent_flag_o,
  input  logic                    undervoltage_flag_o,
  input  logic                    lock_lost_flag_o,
  input  logic                    pll_locked_o,
  output int                      mismatches_o,
  output int                      pending_o,
  output int                      checked_o,
  output int                      lock_events_o,
  output int                      trips_o
);

  localparam int MaxPrinted = 40;

  typedef struct {
    logic signed [SampW-1:0] ia;
    logic signed [SampW-1:0] ib;
    logic signed [SampW-1:0] ic;
    logic signed [SampW-1:0] idc;
    logic signed [SampW-1:0] vdc;
    logic signed [SampW-1:0] vq;
    logic signed [SampW-1:0] dw;
    logic                    req;
    logic                    pll_en;
    logic                    clr;
  } tick_t;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic             pwm;
    logic             ok;
    logic             oc_flag;
    logic             uv_flag;
    logic             lost_flag;
    logic             locked;
  } status_t;

  cfg_t               shadow_cfg;
  logic [ModeW-1:0]   mode_q;
  logic [OcHoldW-1:0] oc_run;
  logic [HoldW-1:0]   lock_run;
  logic               oc_latched;
  logic               uv_latched;
  logic               lost_latched;
  logic               locked_q;

  status_t expected_q[$];
  status_t want;
  status_t got;
  tick_t   tick;
  int      mismatch_cnt;
  int      checked_cnt;
  int      lock_cnt;
  int      trip_cnt;

  assign mismatches_o  = mismatch_cnt;
  assign checked_o     = checked_cnt;
  assign lock_events_o = lock_cnt;
  assign trips_o       = trip_cnt;

  function automatic bit within_tol(int v, int tol);
    return v < tol && v > -tol;
  endfunction

  function automatic bit beyond_lim(int v, int lim);
    return v > lim || v < -lim;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MaxPrinted) $display("%0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [1:0] got_v,
                             input logic [1:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s is %b, want %b on result %0d", name, got_v, want_v,
                                checked_cnt));
  endtask

  // Advance the supervisor state by one control tick and return the status it shows.
  task automatic advance_tick(input tick_t t, output status_t r);
    bit good;
    bit counts;
    bit over_tick;
    bit over;
    bit under;
    bit ok;
    if (t.clr) begin
      oc_latched   = 1'b0;
      uv_latched   = 1'b0;
      lost_latched = 1'b0;
    end

    if (t.pll_en) begin
      good   = within_tol(int'(t.vq), int'(shadow_cfg.vq_tol)) &&
               within_tol(int'(t.dw), int'(shadow_cfg.freq_tol));
      counts = locked_q ? !good : good;
      lock_run = counts ? lock_run + HoldW'(1) : '0;
      if (!locked_q) begin
        if (lock_run >= shadow_cfg.sync_hold) begin
          locked_q = 1'b1;
          lock_run = '0;
          lock_cnt++;
        end
      end else if (lock_run >= shadow_cfg.unsync_hold) begin
        locked_q     = 1'b0;
        lost_latched = 1'b1;
        lock_run     = '0;
      end
    end else begin
      lock_run = '0;
      locked_q = 1'b0;
    end

    // Only the positive sense of the DC current is limited.
    over_tick = beyond_lim(int'(t.ia), int'(shadow_cfg.ac_limit)) ||
                beyond_lim(int'(t.ib), int'(shadow_cfg.ac_limit)) ||
                beyond_lim(int'(t.ic), int'(shadow_cfg.ac_limit)) ||
                (int'(t.idc) > int'(shadow_cfg.dc_limit));
    if (over_tick) begin
      if (oc_run < shadow_cfg.oc_hold) oc_run++;
    end else begin
      oc_run = '0;
    end
    over = oc_run >= shadow_cfg.oc_hold;
    if (over) oc_latched = 1'b1;

    under = int'(t.vdc) < int'(shadow_cfg.vdc_min);
    if (under) uv_latched = 1'b1;
    ok = !under && !over;

    case (mode_q)
      MODE_IDLE: begin
        if (t.req && ok) mode_q = MODE_POWER;
      end
      MODE_POWER: begin
        if (!ok) begin
          mode_q = MODE_ERROR;
          trip_cnt++;
        end else if (!t.req) begin
          mode_q = MODE_IDLE;
        end
      end
      MODE_ERROR: begin
        // leaving error drops every sticky flag
        if (!t.req) begin
          oc_latched   = 1'b0;
          uv_latched   = 1'b0;
          lost_latched = 1'b0;
          mode_q       = MODE_IDLE;
        end
      end
      default: mode_q = MODE_IDLE;
    endcase

    r.mode      = mode_q;
    r.pwm       = (mode_q == MODE_POWER);
    r.ok        = ok;
    r.oc_flag   = oc_latched;
    r.uv_flag   = uv_latched;
    r.lost_flag = lost_latched;
    r.locked    = locked_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cfg.ac_limit    = LimW'(3000);
      shadow_cfg.dc_limit    = LimW'(3000);
      shadow_cfg.oc_hold     = OcHoldW'(3);
      shadow_cfg.vdc_min     = LimW'(4300);
      shadow_cfg.vq_tol      = LimW'(1075);
      shadow_cfg.freq_tol    = LimW'(3142);
      shadow_cfg.sync_hold   = HoldW'(100);
      shadow_cfg.unsync_hold = HoldW'(10);
      mode_q       = MODE_IDLE;
      oc_run       = '0;
      lock_run     = '0;
      oc_latched   = 1'b0;
      uv_latched   = 1'b0;
      lost_latched = 1'b0;
      locked_q     = 1'b0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.mode      = mode_o;
        got.pwm       = pwm_enable_o;
        got.ok        = fault_free_o;
        got.oc_flag   = overcurrent_flag_o;
        got.uv_flag   = undervoltage_flag_o;
        got.lost_flag = lock_lost_flag_o;
        got.locked    = pll_locked_o;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat with no tick waiting (mode %b)", got.mode));
        end else begin
          want = expected_q.pop_front();
          check_field("mode", got.mode, want.mode);
          check_field("pwm_enable", 2'(got.pwm), 2'(want.pwm));
          check_field("fault_free", 2'(got.ok), 2'(want.ok));
          check_field("overcurrent_flag", 2'(got.oc_flag), 2'(want.oc_flag));
          check_field("undervoltage_flag", 2'(got.uv_flag), 2'(want.uv_flag));
          check_field("lock_lost_flag", 2'(got.lost_flag), 2'(want.lost_flag));
          check_field("pll_locked", 2'(got.locked), 2'(want.locked));
        end
        checked_cnt++;
      end

      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_AC_LIMIT:    shadow_cfg.ac_limit    = cfg_wdata_i[LimW-1:0];
          REG_DC_LIMIT:    shadow_cfg.dc_limit    = cfg_wdata_i[LimW-1:0];
          REG_OC_HOLD:     shadow_cfg.oc_hold     = cfg_wdata_i[OcHoldW-1:0];
          REG_VDC_MIN:     shadow_cfg.vdc_min     = cfg_wdata_i[LimW-1:0];
          REG_VQ_TOL:      shadow_cfg.vq_tol      = cfg_wdata_i[LimW-1:0];
          REG_FREQ_TOL:    shadow_cfg.freq_tol    = cfg_wdata_i[LimW-1:0];
          REG_SYNC_HOLD:   shadow_cfg.sync_hold   = cfg_wdata_i[HoldW-1:0];
          REG_UNSYNC_HOLD: shadow_cfg.unsync_hold = cfg_wdata_i[HoldW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_o) begin
        tick.ia     = phase_a_current_i;
        tick.ib     = phase_b_current_i;
        tick.ic     = phase_c_current_i;
        tick.idc    = dc_current_i;
        tick.vdc    = dc_voltage_filtered_i;
        tick.vq     = grid_q_voltage_i;
        tick.dw     = freq_deviation_i;
        tick.req    = request_power_i;
        tick.pll_en = pll_enable_i;
        tick.clr    = clear_flags_i;
        advance_tick(tick, want);
        expected_q.push_back(want);
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> dv/tb_inverter_protection_supervisor.sv
// Testbench top for the inverter protection supervisor: clock, reset, register phases,
// directed and random ticks, receiver stalls and the verdict.
// Depends on ips_pkg, the block and ips_supervisor_checker.
`timescale 1ns / 1ps

module tb_inverter_protection_supervisor;
  import ips_pkg::*;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i;
  logic [CfgAddrW-1:0]     cfg_addr_i;
  logic [CfgDataW-1:0]     cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [SampW-1:0] phase_a_current_i;
  logic signed [SampW-1:0] phase_b_current_i;
  logic signed [SampW-1:0] phase_c_current_i;
  logic signed [SampW-1:0] dc_current_i;
  logic signed [SampW-1:0] dc_voltage_filtered_i;
  logic signed [SampW-1:0] grid_q_voltage_i;
  logic signed [SampW-1:0] freq_deviation_i;
  logic                    request_power_i;
  logic                    pll_enable_i;
  logic                    clear_flags_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [ModeW-1:0]        mode_o;
  logic                    pwm_enable_o;
  logic                    fault_free_o;
  logic                    overcurrent_flag_o;
  logic                    undervoltage_flag_o;
  logic                    lock_lost_flag_o;
  logic                    pll_locked_o;

  int mismatches;
  int pending;
  int checked;
  int lock_events;
  int trips;

  cfg_t live_cfg;
  bit   quiet;
  bit   hold_off_req;
  bit   lk_good;
  int   lk_left;
  bit   oc_over;
  int   oc_left;
  bit   req_on;
  int   req_left;
  int   ticks_sent;
  int   settings_cnt;

  inverter_protection_supervisor dut (.*);

  ips_supervisor_checker u_checker (
    .*,
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .lock_events_o(lock_events),
    .trips_o      (trips)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("timeout with %0d results still outstanding", pending);
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request so the block backs up.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        for (int k = 0; k < 60; k++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        hold_off_req = 1'b0;
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 22);
    end
  end

  function automatic int pick_in(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Lock window samples: good means strictly inside +/- tol.
  function automatic int lock_sample(int tol, bit good);
    int mag;
    if (good && tol > 0) begin
      mag = ($urandom_range(3) == 0) ? tol - 1 : int'($urandom_range(tol - 1));
      return $urandom_range(1) ? mag : -mag;
    end
    mag = ($urandom_range(3) == 0) ? tol : pick_in(tol, 32767);
    if ($urandom_range(1)) return mag;
    return ($urandom_range(7) == 0) ? -32768 : -mag;
  endfunction

  function automatic int current_sample(int lim, bit over);
    int mag;
    if (!over) begin
      mag = ($urandom_range(3) == 0) ? lim : int'($urandom_range(lim));
      return $urandom_range(1) ? mag : -mag;
    end
    if (lim >= 32767) return -32768;
    mag = ($urandom_range(3) == 0) ? lim + 1 : pick_in(lim + 1, 32767);
    if ($urandom_range(1)) return mag;
    return ($urandom_range(7) == 0) ? -32768 : -mag;
  endfunction

  // Half the runs reach or just pass the hold (capped at 150), the rest are no longer than it.
  function automatic int run_length(int hold);
    int cap;
    cap = (hold > 150) ? 150 : ((hold < 1) ? 1 : hold);
    if ($urandom_range(1)) return cap + int'($urandom_range(2));
    return 1 + int'($urandom_range(cap - 1));
  endfunction

  task automatic send_tick(input int ia, input int ib, input int ic, input int idc,
                           input int vdc, input int vq, input int dw,
                           input bit req, input bit pll, input bit clr);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    phase_a_current_i     <= SampW'(ia);
    phase_b_current_i     <= SampW'(ib);
    phase_c_current_i     <= SampW'(ic);
    dc_current_i          <= SampW'(idc);
    dc_voltage_filtered_i <= SampW'(vdc);
    grid_q_voltage_i      <= SampW'(vq);
    freq_deviation_i      <= SampW'(dw);
    request_power_i       <= req;
    pll_enable_i          <= pll;
    clear_flags_i         <= clr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  task automatic random_tick();
    int ia;
    int ib;
    int ic;
    int idc;
    int vdc;
    int vq;
    int dw;
    int src;
    if ($urandom_range(99) < 8) begin
      send_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                1'($urandom), 1'($urandom), 1'($urandom));
      return;
    end

    if (lk_left == 0) begin
      lk_good = $urandom_range(99) < 65;
      lk_left = run_length(lk_good ? int'(live_cfg.sync_hold) : int'(live_cfg.unsync_hold));
    end
    lk_left--;
    src = $urandom_range(2);
    vq  = lock_sample(int'(live_cfg.vq_tol), lk_good || src == 1);
    dw  = lock_sample(int'(live_cfg.freq_tol), lk_good || src == 0);

    if (oc_left == 0) begin
      oc_over = $urandom_range(99) < 35;
      oc_left = oc_over ? run_length(int'(live_cfg.oc_hold)) : 1 + int'($urandom_range(20));
    end
    oc_left--;
    ia  = current_sample(int'(live_cfg.ac_limit), 1'b0);
    ib  = current_sample(int'(live_cfg.ac_limit), 1'b0);
    ic  = current_sample(int'(live_cfg.ac_limit), 1'b0);
    idc = $urandom_range(1) ? pick_in(-32768, int'(live_cfg.dc_limit)) :
          int'(live_cfg.dc_limit);
    if (oc_over) begin
      src = $urandom_range(3);
      if (src == 3 && live_cfg.dc_limit >= 15'd32767) src = 0;
      case (src)
        0: ia = current_sample(int'(live_cfg.ac_limit), 1'b1);
        1: ib = current_sample(int'(live_cfg.ac_limit), 1'b1);
        2: ic = current_sample(int'(live_cfg.ac_limit), 1'b1);
        default: idc = ($urandom_range(3) == 0) ? int'(live_cfg.dc_limit) + 1 :
                       pick_in(int'(live_cfg.dc_limit) + 1, 32767);
      endcase
    end

    if ($urandom_range(99) < 6)
      vdc = $urandom_range(1) ? int'(live_cfg.vdc_min) - 1 :
            pick_in(-32768, int'(live_cfg.vdc_min) - 1);
    else
      vdc = $urandom_range(3) == 0 ? int'(live_cfg.vdc_min) :
            pick_in(int'(live_cfg.vdc_min), 32767);

    if (req_left == 0) begin
      req_on   = $urandom_range(99) < 85;
      req_left = 1 + int'($urandom_range(req_on ? 40 : 6));
    end
    req_left--;

    send_tick(ia, ib, ic, idc, vdc, vq, dw, req_on,
              $urandom_range(99) < 96, $urandom_range(99) < 3);
  endtask

  // Wait until every predicted result has been taken.
  task automatic settle();
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Upper bits beyond each register's width are random and must be dropped.
  task automatic apply_cfg(input cfg_t c);
    write_reg(REG_AC_LIMIT,    {1'($urandom), c.ac_limit});
    write_reg(REG_DC_LIMIT,    {1'($urandom), c.dc_limit});
    write_reg(REG_OC_HOLD,     {8'($urandom), c.oc_hold});
    write_reg(REG_VDC_MIN,     {1'($urandom), c.vdc_min});
    write_reg(REG_VQ_TOL,      {1'($urandom), c.vq_tol});
    write_reg(REG_FREQ_TOL,    {1'($urandom), c.freq_tol});
    write_reg(REG_SYNC_HOLD,   c.sync_hold);
    write_reg(REG_UNSYNC_HOLD, c.unsync_hold);
    cfg_we_i <= 1'b0;
    live_cfg = c;
    settings_cnt++;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.ac_limit    = LimW'(pick_in(500, 20000));
    c.dc_limit    = LimW'(pick_in(500, 20000));
    c.oc_hold     = OcHoldW'(1 + $urandom_range(5));
    c.vdc_min     = LimW'(pick_in(0, 8000));
    c.vq_tol      = LimW'(pick_in(1, 3000));
    c.freq_tol    = LimW'(pick_in(1, 5000));
    c.sync_hold   = HoldW'(1 + $urandom_range(15));
    c.unsync_hold = HoldW'(1 + $urandom_range(7));
    return c;
  endfunction

  task automatic run_phase(input cfg_t c, input int n, input int hold_off_at,
                           input int quiet_upto);
    settle();
    apply_cfg(c);
    lk_left  = 0;
    oc_left  = 0;
    req_left = 0;
    for (int i = 0; i < n; i++) begin
      quiet = (i < quiet_upto);
      if (i == hold_off_at) hold_off_req = 1'b1;
      random_tick();
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;
  endtask

  initial begin
    cfg_we_i              <= 1'b0;
    cfg_addr_i            <= '0;
    cfg_wdata_i           <= '0;
    in_valid_i            <= 1'b0;
    phase_a_current_i     <= '0;
    phase_b_current_i     <= '0;
    phase_c_current_i     <= '0;
    dc_current_i          <= '0;
    dc_voltage_filtered_i <= '0;
    grid_q_voltage_i      <= '0;
    freq_deviation_i      <= '0;
    request_power_i       <= 1'b0;
    pll_enable_i          <= 1'b0;
    clear_flags_i         <= 1'b0;
    live_cfg = '{ac_limit: LimW'(3000), dc_limit: LimW'(3000), oc_hold: OcHoldW'(3),
                 vdc_min: LimW'(4300), vq_tol: LimW'(1075), freq_tol: LimW'(3142),
                 sync_hold: HoldW'(100), unsync_hold: HoldW'(10)};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at the reset settings: limits on both sides, idle-power-error-idle mode moves.
    send_tick(0, 0, 0, 0, 5000, 0, 0, 1'b0, 1'b1, 1'b0);
    send_tick(0, 0, 0, 0, 5000, 0, 0, 1'b1, 1'b1, 1'b0);
    send_tick(3000, -3000, 3000, 3000, 4300, 1074, 3141, 1'b1, 1'b1, 1'b0);
    send_tick(3001, 0, 0, 0, 5000, 1075, -3141, 1'b1, 1'b1, 1'b0);
    send_tick(0, -3001, 0, 0, 5000, 0, 3142, 1'b1, 1'b1, 1'b0);
    send_tick(0, 0, 32767, 0, 5000, -1075, -3142, 1'b1, 1'b1, 1'b0);
    send_tick(0, 0, 0, -32768, 5000, 0, 0, 1'b1, 1'b1, 1'b0);
    send_tick(0, 0, 0, 0, 5000, 0, 0, 1'b1, 1'b1, 1'b1);
    send_tick(0, 0, 0, 3001, 5000, 0, 0, 1'b1, 1'b1, 1'b0);
    send_tick(0, 0, 0, 0, 5000, 0, 0, 1'b0, 1'b1, 1'b0);
    send_tick(0, 0, 0, 0, 4299, 0, 0, 1'b1, 1'b1, 1'b0);
    send_tick(0, 0, 0, 0, 4300, 0, 0, 1'b1, 1'b1, 1'b0);
    send_tick(0, 0, 0, 0, -32768, 0, 0, 1'b1, 1'b0, 1'b0);
    send_tick(0, 0, 0, 0, -32768, 0, 0, 1'b0, 1'b0, 1'b0);
    send_tick(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1, 1'b1, 1'b1);
    send_tick(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1, 1'b1, 1'b0);
    send_tick(0, 0, 0, 0, 32767, 0, 0, 1'b1, 1'b0, 1'b1);
    send_tick(-1, -1, -1, -1, -1, -1, -1, 1'b1, 1'b1, 1'b0);
    send_tick(21845, -21846, 21845, -21846, 21845, -21846, 21845, 1'b0, 1'b1, 1'b1);
    send_tick(0, 0, 0, 0, 5000, 0, 0, 1'b0, 1'b0, 1'b0);
    in_valid_i <= 1'b0;

    // Reset settings written back, then short holds, then the extremes, then random.
    run_phase('{ac_limit: LimW'(3000), dc_limit: LimW'(3000), oc_hold: OcHoldW'(3),
                vdc_min: LimW'(4300), vq_tol: LimW'(1075), freq_tol: LimW'(3142),
                sync_hold: HoldW'(100), unsync_hold: HoldW'(10)}, 350, -1, 0);
    run_phase('{ac_limit: LimW'(2000), dc_limit: LimW'(1500), oc_hold: OcHoldW'(1),
                vdc_min: LimW'(1000), vq_tol: LimW'(500), freq_tol: LimW'(800),
                sync_hold: HoldW'(4), unsync_hold: HoldW'(2)}, 400, 120, 0);
    run_phase('{ac_limit: LimW'(32767), dc_limit: LimW'(32767), oc_hold: OcHoldW'(255),
                vdc_min: LimW'(32767), vq_tol: LimW'(32767), freq_tol: LimW'(32767),
                sync_hold: HoldW'(65535), unsync_hold: HoldW'(65535)}, 150, -1, 0);
    // Zero holds: every tick is a debounced fault and lock moves on the first tick.
    run_phase('{ac_limit: '0, dc_limit: '0, oc_hold: '0, vdc_min: '0, vq_tol: '0,
                freq_tol: '0, sync_hold: '0, unsync_hold: '0}, 150, -1, 0);
    run_phase(random_cfg(), 400, 300, 250);
    run_phase(random_cfg(), 400, -1, 0);

    settle();
    repeat (4) @(posedge clk_i);
    $display("Summary: %0d ticks under %0d register settings, %0d results compared",
             ticks_sent, settings_cnt, checked);
    $display("Summary: %0d lock acquisitions and %0d power-to-error trips predicted",
             lock_events, trips);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/ips_pkg.sv
hdl/ips_cfg.sv
hdl/ips_lock.sv
hdl/ips_prot.sv
hdl/inverter_protection_supervisor.sv
dv/ips_supervisor_checker.sv
dv/tb_inverter_protection_supervisor.sv
